FILE: hdl/trsb_pkg.sv
// ----------------------------------------------------------------------------
// trsb_pkg
// Types, constants and helpers shared by the retention buffer modules.
// ----------------------------------------------------------------------------
package trsb_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int STAMP_W = 63;
  localparam int PAY_W   = 64;
  localparam int DIST_W  = 32;
  localparam int RET_W   = 40;
  localparam logic [RET_W-1:0] RET_RESET = 40'd1000000000;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_QUERY = 2'd1,
    OP_GATE  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [STAMP_W-1:0] stamp;
    logic [STAMP_W-1:0] stamp_end;
    logic [PAY_W-1:0]   payload;
    logic               rejected;
    logic               evaluated;
    logic [DIST_W-1:0]  distance;
  } cmd_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [PAY_W-1:0]   payload;
    logic               rejected;
    logic               evaluated;
    logic [DIST_W-1:0]  distance;
  } entry_t;

  typedef struct packed {
    logic               entry_valid;
    entry_t             ent;
    logic               last;
    logic [CNT_W-1:0]   entry_count;
    logic [STAMP_W-1:0] newest_stamp;
    logic               gate_matched;
    logic               overflow;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EV_RD,
    ST_EV_CMP,
    ST_PUSH_DEC,
    ST_FULL_CMP,
    ST_INS_RD,
    ST_INS_CMP,
    ST_Q_RD,
    ST_Q_CMP,
    ST_G_RD,
    ST_G_CMP,
    ST_FIN
  } state_t;

  // Physical slot of a logical position in the ring.
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                             input logic [CNT_W-1:0] pos);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(pos);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

FILE: hdl/trsb_ifs.sv
// ----------------------------------------------------------------------------
// trsb_ifs
// Valid/ready channel interfaces for input items, results and configuration.
// ----------------------------------------------------------------------------
interface trsb_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     operation;
  logic [trsb_pkg::STAMP_W-1:0]   stamp;
  logic [trsb_pkg::STAMP_W-1:0]   stamp_end;
  logic [trsb_pkg::PAY_W-1:0]     payload;
  logic                           rejected_in;
  logic                           evaluated_in;
  logic [trsb_pkg::DIST_W-1:0]    distance_in;
  modport source (output valid, operation, stamp, stamp_end, payload, rejected_in,
                  evaluated_in, distance_in, input ready);
  modport sink (input valid, operation, stamp, stamp_end, payload, rejected_in,
                evaluated_in, distance_in, output ready);
endinterface

interface trsb_out_if;
  logic                           valid;
  logic                           ready;
  logic                           entry_valid;
  logic [trsb_pkg::STAMP_W-1:0]   entry_stamp;
  logic [trsb_pkg::PAY_W-1:0]     entry_payload;
  logic                           entry_rejected;
  logic                           entry_evaluated;
  logic [trsb_pkg::DIST_W-1:0]    entry_distance;
  logic                           last;
  logic [trsb_pkg::CNT_W-1:0]     entry_count;
  logic [trsb_pkg::STAMP_W-1:0]   newest_stamp;
  logic                           gate_matched;
  logic                           overflow;
  modport source (output valid, entry_valid, entry_stamp, entry_payload, entry_rejected,
                  entry_evaluated, entry_distance, last, entry_count, newest_stamp,
                  gate_matched, overflow, input ready);
  modport sink (input valid, entry_valid, entry_stamp, entry_payload, entry_rejected,
                entry_evaluated, entry_distance, last, entry_count, newest_stamp,
                gate_matched, overflow, output ready);
endinterface

interface trsb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [trsb_pkg::RET_W-1:0]     data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: hdl/trsb_front.sv
// ----------------------------------------------------------------------------
// trsb_front
// Accepts input items, decodes the operation and queues up to two commands.
// ----------------------------------------------------------------------------
module trsb_front (
  input  logic              clk,
  input  logic              rst_n,
  trsb_in_if.sink           in_ch,
  output logic              cmd_valid,
  output trsb_pkg::cmd_t    cmd,
  input  logic              cmd_pop
);

  trsb_pkg::cmd_t q_r [2];
  logic           rd_ptr_r, rd_ptr_nxt;
  logic           wr_ptr_r, wr_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;
  logic           pop;
  trsb_pkg::cmd_t in_cmd;

  always_comb begin
    in_cmd.op        = trsb_pkg::op_t'(in_ch.operation);
    in_cmd.stamp     = in_ch.stamp;
    in_cmd.stamp_end = in_ch.stamp_end;
    in_cmd.payload   = in_ch.payload;
    in_cmd.rejected  = in_ch.rejected_in;
    in_cmd.evaluated = in_ch.evaluated_in;
    in_cmd.distance  = in_ch.distance_in;
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = cmd_pop && (cnt_r != 2'd0);
  assign cmd_valid   = (cnt_r != 2'd0);
  assign cmd         = q_r[rd_ptr_r];

  always_comb begin
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

FILE: hdl/trsb_back.sv
// ----------------------------------------------------------------------------
// trsb_back
// Sequencer over the sorted ring memory: eviction, insertion, query and gate
// scans, with the result register toward the output channel.
// ----------------------------------------------------------------------------
module trsb_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [trsb_pkg::RET_W-1:0]   retention,
  input  logic                         cmd_valid,
  input  trsb_pkg::cmd_t               cmd,
  output logic                         cmd_pop,
  trsb_out_if.source                   out_ch
);

  trsb_pkg::entry_t mem [trsb_pkg::DEPTH];
  trsb_pkg::entry_t rdata_r;

  trsb_pkg::state_t                 state_r, state_nxt;
  logic [trsb_pkg::IDX_W-1:0]       head_r, head_nxt;
  logic [trsb_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [trsb_pkg::CNT_W-1:0]       idx_r, idx_nxt;
  logic [trsb_pkg::STAMP_W-1:0]     newest_r, newest_nxt;
  trsb_pkg::cmd_t                   cmd_r, cmd_nxt;
  logic [trsb_pkg::STAMP_W:0]       top_r, top_nxt;
  logic                             pend_vld_r, pend_vld_nxt;
  trsb_pkg::entry_t                 pend_r, pend_nxt;
  logic                             res_vld_r, res_vld_nxt;
  trsb_pkg::entry_t                 res_ent_r, res_ent_nxt;
  logic                             gm_r, gm_nxt;
  logic                             ovf_r, ovf_nxt;
  logic                             ovld_r, ovld_nxt;
  trsb_pkg::res_t                   out_r, out_nxt;

  logic                             we;
  logic [trsb_pkg::IDX_W-1:0]       waddr;
  trsb_pkg::entry_t                 wdata;
  logic                             rd_en;
  logic [trsb_pkg::IDX_W-1:0]       raddr;

  logic                             can_emit;
  logic [trsb_pkg::STAMP_W:0]       s_ext;
  logic [trsb_pkg::STAMP_W:0]       s_plus_ret;
  logic [trsb_pkg::STAMP_W:0]       r_plus_ret;
  logic [trsb_pkg::STAMP_W-1:0]     gate_lo;
  logic [trsb_pkg::STAMP_W:0]       gate_hi;
  trsb_pkg::entry_t                 new_ent;
  trsb_pkg::entry_t                 upd_ent;
  logic                             q_match;

  assign can_emit   = !ovld_r || out_ch.ready;
  assign s_ext      = {1'b0, cmd_r.stamp};
  assign s_plus_ret = s_ext + (trsb_pkg::STAMP_W+1)'(retention);
  assign r_plus_ret = {1'b0, rdata_r.stamp} + (trsb_pkg::STAMP_W+1)'(retention);
  assign gate_lo    = (cmd_r.stamp != '0) ? cmd_r.stamp - trsb_pkg::STAMP_W'(1) : '0;
  assign gate_hi    = s_ext + (trsb_pkg::STAMP_W+1)'(1);
  assign q_match    = (rdata_r.stamp > cmd_r.stamp) && (rdata_r.stamp <= cmd_r.stamp_end);

  always_comb begin
    new_ent.stamp     = cmd_r.stamp;
    new_ent.payload   = cmd_r.payload;
    new_ent.rejected  = cmd_r.rejected;
    new_ent.evaluated = cmd_r.evaluated;
    new_ent.distance  = cmd_r.distance;
    upd_ent           = rdata_r;
    upd_ent.rejected  = cmd_r.rejected;
    upd_ent.evaluated = cmd_r.evaluated;
    upd_ent.distance  = cmd_r.distance;
  end

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    newest_nxt   = newest_r;
    cmd_nxt      = cmd_r;
    top_nxt      = top_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    res_vld_nxt  = res_vld_r;
    res_ent_nxt  = res_ent_r;
    gm_nxt       = gm_r;
    ovf_nxt      = ovf_r;
    ovld_nxt     = ovld_r && !out_ch.ready;
    out_nxt      = out_r;
    cmd_pop      = 1'b0;
    we           = 1'b0;
    waddr        = trsb_pkg::phys(head_r, idx_r);
    wdata        = new_ent;
    rd_en        = 1'b0;
    raddr        = head_r;

    unique case (state_r)
      trsb_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop      = 1'b1;
          cmd_nxt      = cmd;
          idx_nxt      = '0;
          pend_vld_nxt = 1'b0;
          res_vld_nxt  = 1'b0;
          gm_nxt       = 1'b0;
          ovf_nxt      = 1'b0;
          top_nxt      = (count_r != '0 && newest_r > cmd.stamp) ?
                         {1'b0, newest_r} : {1'b0, cmd.stamp};
          unique case (cmd.op)
            trsb_pkg::OP_PUSH:  state_nxt = trsb_pkg::ST_EV_RD;
            trsb_pkg::OP_QUERY: state_nxt = trsb_pkg::ST_Q_RD;
            trsb_pkg::OP_GATE:  state_nxt = trsb_pkg::ST_G_RD;
            trsb_pkg::OP_CLEAR: begin
              count_nxt  = '0;
              head_nxt   = '0;
              newest_nxt = '0;
              state_nxt  = trsb_pkg::ST_FIN;
            end
            default: state_nxt = trsb_pkg::ST_IDLE;
          endcase
        end
      end
      trsb_pkg::ST_EV_RD: begin
        if (count_r == '0) begin
          state_nxt = trsb_pkg::ST_PUSH_DEC;
        end else begin
          rd_en     = 1'b1;
          raddr     = head_r;
          state_nxt = trsb_pkg::ST_EV_CMP;
        end
      end
      trsb_pkg::ST_EV_CMP: begin
        if (r_plus_ret < top_r) begin
          head_nxt  = trsb_pkg::phys(head_r, trsb_pkg::CNT_W'(1));
          count_nxt = count_r - trsb_pkg::CNT_W'(1);
          // Evicting the last entry leaves an empty store.
          if (count_r == trsb_pkg::CNT_W'(1)) begin
            newest_nxt = '0;
          end
          state_nxt = trsb_pkg::ST_EV_RD;
        end else begin
          state_nxt = trsb_pkg::ST_PUSH_DEC;
        end
      end
      trsb_pkg::ST_PUSH_DEC: begin
        if (s_plus_ret < top_r) begin
          state_nxt = trsb_pkg::ST_FIN;
        end else if (count_r >= trsb_pkg::CNT_W'(trsb_pkg::DEPTH)) begin
          ovf_nxt   = 1'b1;
          rd_en     = 1'b1;
          raddr     = head_r;
          state_nxt = trsb_pkg::ST_FULL_CMP;
        end else begin
          idx_nxt   = count_r;
          state_nxt = trsb_pkg::ST_INS_RD;
        end
      end
      trsb_pkg::ST_FULL_CMP: begin
        // A sample older than every stored entry is itself the one dropped.
        if (cmd_r.stamp < rdata_r.stamp) begin
          state_nxt = trsb_pkg::ST_FIN;
        end else begin
          head_nxt  = trsb_pkg::phys(head_r, trsb_pkg::CNT_W'(1));
          count_nxt = count_r - trsb_pkg::CNT_W'(1);
          idx_nxt   = count_r - trsb_pkg::CNT_W'(1);
          state_nxt = trsb_pkg::ST_INS_RD;
        end
      end
      trsb_pkg::ST_INS_RD: begin
        if (idx_r == '0) begin
          we         = 1'b1;
          waddr      = trsb_pkg::phys(head_r, idx_r);
          wdata      = new_ent;
          count_nxt  = count_r + trsb_pkg::CNT_W'(1);
          newest_nxt = (count_r == '0 || cmd_r.stamp > newest_r) ? cmd_r.stamp : newest_r;
          state_nxt  = trsb_pkg::ST_FIN;
        end else begin
          rd_en     = 1'b1;
          raddr     = trsb_pkg::phys(head_r, idx_r - trsb_pkg::CNT_W'(1));
          state_nxt = trsb_pkg::ST_INS_CMP;
        end
      end
      trsb_pkg::ST_INS_CMP: begin
        // Walk from the back, moving each later entry up by one slot.
        we    = 1'b1;
        waddr = trsb_pkg::phys(head_r, idx_r);
        if (rdata_r.stamp > cmd_r.stamp) begin
          wdata     = rdata_r;
          idx_nxt   = idx_r - trsb_pkg::CNT_W'(1);
          state_nxt = trsb_pkg::ST_INS_RD;
        end else begin
          wdata      = new_ent;
          count_nxt  = count_r + trsb_pkg::CNT_W'(1);
          newest_nxt = (count_r == '0 || cmd_r.stamp > newest_r) ? cmd_r.stamp : newest_r;
          state_nxt  = trsb_pkg::ST_FIN;
        end
      end
      trsb_pkg::ST_Q_RD: begin
        if (idx_r == count_r) begin
          res_vld_nxt = pend_vld_r;
          res_ent_nxt = pend_r;
          state_nxt   = trsb_pkg::ST_FIN;
        end else begin
          rd_en     = 1'b1;
          raddr     = trsb_pkg::phys(head_r, idx_r);
          state_nxt = trsb_pkg::ST_Q_CMP;
        end
      end
      trsb_pkg::ST_Q_CMP: begin
        // The held match goes out only once a later one shows it is not last.
        if (!(q_match && pend_vld_r && !can_emit)) begin
          if (q_match && pend_vld_r) begin
            ovld_nxt             = 1'b1;
            out_nxt.entry_valid  = 1'b1;
            out_nxt.ent          = pend_r;
            out_nxt.last         = 1'b0;
            out_nxt.entry_count  = count_r;
            out_nxt.newest_stamp = newest_r;
            out_nxt.gate_matched = 1'b0;
            out_nxt.overflow     = 1'b0;
          end
          if (q_match) begin
            pend_vld_nxt = 1'b1;
            pend_nxt     = rdata_r;
          end
          idx_nxt   = idx_r + trsb_pkg::CNT_W'(1);
          state_nxt = trsb_pkg::ST_Q_RD;
        end
      end
      trsb_pkg::ST_G_RD: begin
        if (idx_r == count_r) begin
          state_nxt = trsb_pkg::ST_FIN;
        end else begin
          rd_en     = 1'b1;
          raddr     = trsb_pkg::phys(head_r, idx_r);
          state_nxt = trsb_pkg::ST_G_CMP;
        end
      end
      trsb_pkg::ST_G_CMP: begin
        if (rdata_r.stamp < gate_lo) begin
          idx_nxt   = idx_r + trsb_pkg::CNT_W'(1);
          state_nxt = trsb_pkg::ST_G_RD;
        end else begin
          if ({1'b0, rdata_r.stamp} <= gate_hi) begin
            we          = 1'b1;
            waddr       = trsb_pkg::phys(head_r, idx_r);
            wdata       = upd_ent;
            res_vld_nxt = 1'b1;
            res_ent_nxt = upd_ent;
            gm_nxt      = 1'b1;
          end
          state_nxt = trsb_pkg::ST_FIN;
        end
      end
      trsb_pkg::ST_FIN: begin
        if (can_emit) begin
          ovld_nxt             = 1'b1;
          out_nxt.entry_valid  = res_vld_r;
          out_nxt.ent          = res_vld_r ? res_ent_r : '0;
          out_nxt.last         = 1'b1;
          out_nxt.entry_count  = count_r;
          out_nxt.newest_stamp = newest_r;
          out_nxt.gate_matched = gm_r;
          out_nxt.overflow     = ovf_r;
          state_nxt            = trsb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = trsb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= trsb_pkg::ST_IDLE;
      head_r   <= '0;
      count_r  <= '0;
      newest_r <= '0;
      ovld_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      newest_r <= newest_nxt;
      ovld_r   <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cmd_r      <= cmd_nxt;
    top_r      <= top_nxt;
    pend_vld_r <= pend_vld_nxt;
    pend_r     <= pend_nxt;
    res_vld_r  <= res_vld_nxt;
    res_ent_r  <= res_ent_nxt;
    gm_r       <= gm_nxt;
    ovf_r      <= ovf_nxt;
    out_r      <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign out_ch.valid           = ovld_r;
  assign out_ch.entry_valid     = out_r.entry_valid;
  assign out_ch.entry_stamp     = out_r.ent.stamp;
  assign out_ch.entry_payload   = out_r.ent.payload;
  assign out_ch.entry_rejected  = out_r.ent.rejected;
  assign out_ch.entry_evaluated = out_r.ent.evaluated;
  assign out_ch.entry_distance  = out_r.ent.distance;
  assign out_ch.last            = out_r.last;
  assign out_ch.entry_count     = out_r.entry_count;
  assign out_ch.newest_stamp    = out_r.newest_stamp;
  assign out_ch.gate_matched    = out_r.gate_matched;
  assign out_ch.overflow        = out_r.overflow;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= trsb_pkg::CNT_W'(trsb_pkg::DEPTH))
    else $error("fill count above depth");
  a_empty_newest: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (newest_r == '0))
    else $error("empty buffer reports a newest stamp");
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == trsb_pkg::ST_INS_RD || state_r == trsb_pkg::ST_INS_CMP ||
            state_r == trsb_pkg::ST_G_CMP))
    else $error("memory written outside insert or gate update");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && !out_ch.ready) |=> ovld_r)
    else $error("stalled result lost");
`endif

endmodule

FILE: hdl/timestamp_sorted_retention_buffer.sv
// ----------------------------------------------------------------------------
// timestamp_sorted_retention_buffer
// Stamp-ordered store of motion samples with retention, query and gate update.
// ----------------------------------------------------------------------------
// Usage: items enter on in_ch (push, range query, gate update, clear) and
// results leave on out_ch, one per item except a query, which gives one per
// match with last set on the final one, or a single empty result.
// cfg_ch writes the retention window; it is always ready. It is to be
// written while the block is idle; the block itself does not enforce this.
// A front queue holds two decoded items, so the source keeps going while the
// back sequencer works. The back walks the ring memory one entry at a time
// through its single read port, a read state and then a compare state per
// entry. From taking an item to loading the final result into the output
// register, a push walks the evicted entries and the entries stamped after
// the sample, a gate update the entries below the match window, a query
// every stored entry, and a clear walks none.
// Results sit in an output register; while the receiver stalls, the
// sequencer holds in place and the queue fills, then in_ch.ready drops.
// Reset is synchronous (rst_n low): the store is empty, retention returns to
// one second, and no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module timestamp_sorted_retention_buffer (
  input  logic        clk,
  input  logic        rst_n,
  trsb_in_if.sink     in_ch,
  trsb_out_if.source  out_ch,
  trsb_cfg_if.sink    cfg_ch
);

  logic [trsb_pkg::RET_W-1:0] ret_r, ret_nxt;
  logic                       cmd_valid;
  trsb_pkg::cmd_t             cmd;
  logic                       cmd_pop;

  assign cfg_ch.ready = 1'b1;
  assign ret_nxt      = cfg_ch.valid ? cfg_ch.data : ret_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ret_r <= trsb_pkg::RET_RESET;
    end else begin
      ret_r <= ret_nxt;
    end
  end

  trsb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  trsb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .retention (ret_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

endmodule

FILE: dv/trsb_checker.sv
// ----------------------------------------------------------------------------
// trsb_checker
// Watches the item, result and retention channels of the retention buffer,
// keeps its own sorted copy of the store and compares every result in order.
// ----------------------------------------------------------------------------
module trsb_checker (
  input  logic        clk,
  input  logic        rst_n,
  trsb_in_if.sink     in_mon,
  trsb_out_if.sink    out_mon,
  trsb_cfg_if.sink    cfg_mon,
  output int          fail_count,
  output int          pending_results
);

  timeunit 1ns;
  timeprecision 1ps;

  trsb_pkg::entry_t           store_q[$];
  logic [trsb_pkg::RET_W-1:0] window_ns;
  trsb_pkg::res_t             expected_q[$];

  assign pending_results = expected_q.size();

  function automatic trsb_pkg::res_t status(logic is_last);
    trsb_pkg::res_t r;
    r = '0;
    r.last = is_last;
    r.entry_count = trsb_pkg::CNT_W'(store_q.size());
    r.newest_stamp = store_q.size() ? store_q[$].stamp : '0;
    return r;
  endfunction

  // Applies one accepted item to the store copy and queues its results.
  task automatic predict_item(trsb_pkg::cmd_t c);
    logic [63:0]      top, lo;
    trsb_pkg::res_t   r;
    trsb_pkg::entry_t e;
    int               pos, hits;
    begin
      case (c.op)
        trsb_pkg::OP_PUSH: begin
          top = (store_q.size() && store_q[$].stamp > c.stamp) ? store_q[$].stamp : c.stamp;
          while (store_q.size() && 64'(store_q[0].stamp) + window_ns < top)
            store_q.delete(0);
          e = '{c.stamp, c.payload, c.rejected, c.evaluated, c.distance};
          r = status(1'b1);
          if (64'(c.stamp) + window_ns >= top) begin
            if (store_q.size() >= trsb_pkg::DEPTH) begin
              r.overflow = 1'b1;
              if (c.stamp < store_q[0].stamp) begin
                r = status(1'b1);
                r.overflow = 1'b1;
                expected_q.insert(expected_q.size(), r);
                return;
              end
              store_q.delete(0);
            end
            pos = 0;
            while (pos < store_q.size() && store_q[pos].stamp <= c.stamp) pos++;
            store_q.insert(pos, e);
            r.entry_count = trsb_pkg::CNT_W'(store_q.size());
            r.newest_stamp = store_q[$].stamp;
          end
          expected_q.insert(expected_q.size(), r);
        end
        trsb_pkg::OP_QUERY: begin
          hits = 0;
          foreach (store_q[i]) begin
            if (store_q[i].stamp > c.stamp && store_q[i].stamp <= c.stamp_end) begin
              r = status(1'b0);
              r.entry_valid = 1'b1;
              r.ent = store_q[i];
              expected_q.insert(expected_q.size(), r);
              hits++;
            end
          end
          if (hits == 0) expected_q.insert(expected_q.size(), status(1'b1));
          else expected_q[$].last = 1'b1;
        end
        trsb_pkg::OP_GATE: begin
          lo = c.stamp ? 64'(c.stamp) - 1 : 64'd0;
          pos = 0;
          while (pos < store_q.size() && store_q[pos].stamp < lo) pos++;
          r = status(1'b1);
          if (pos < store_q.size() && 64'(store_q[pos].stamp) <= 64'(c.stamp) + 1) begin
            store_q[pos].rejected = c.rejected;
            store_q[pos].evaluated = c.evaluated;
            store_q[pos].distance = c.distance;
            r.entry_valid = 1'b1;
            r.ent = store_q[pos];
            r.gate_matched = 1'b1;
          end
          expected_q.insert(expected_q.size(), r);
        end
        default: begin
          store_q.delete();
          expected_q.insert(expected_q.size(), status(1'b1));
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    trsb_pkg::cmd_t c;
    trsb_pkg::res_t got, want;
    if (!rst_n) begin
      store_q.delete();
      expected_q.delete();
      window_ns <= trsb_pkg::RET_RESET;
      fail_count <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) window_ns <= cfg_mon.data;
      if (in_mon.valid && in_mon.ready) begin
        c.op = trsb_pkg::op_t'(in_mon.operation);
        c.stamp = in_mon.stamp;
        c.stamp_end = in_mon.stamp_end;
        c.payload = in_mon.payload;
        c.rejected = in_mon.rejected_in;
        c.evaluated = in_mon.evaluated_in;
        c.distance = in_mon.distance_in;
        predict_item(c);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.entry_valid = out_mon.entry_valid;
        got.ent = '{out_mon.entry_stamp, out_mon.entry_payload, out_mon.entry_rejected,
                    out_mon.entry_evaluated, out_mon.entry_distance};
        got.last = out_mon.last;
        got.entry_count = out_mon.entry_count;
        got.newest_stamp = out_mon.newest_stamp;
        got.gate_matched = out_mon.gate_matched;
        got.overflow = out_mon.overflow;
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("result mismatch");
              $display("  expected valid=%b stamp=%h pay=%h rej=%b ev=%b dist=%h",
                       want.entry_valid, want.ent.stamp, want.ent.payload,
                       want.ent.rejected, want.ent.evaluated, want.ent.distance);
              $display("  actual   valid=%b stamp=%h pay=%h rej=%b ev=%b dist=%h",
                       got.entry_valid, got.ent.stamp, got.ent.payload,
                       got.ent.rejected, got.ent.evaluated, got.ent.distance);
              $display("  expected last=%b cnt=%0d newest=%h gm=%b ovf=%b", want.last,
                       want.entry_count, want.newest_stamp, want.gate_matched,
                       want.overflow);
              $display("  actual   last=%b cnt=%0d newest=%h gm=%b ovf=%b", got.last,
                       got.entry_count, got.newest_stamp, got.gate_matched,
                       got.overflow);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: dv/tb_timestamp_sorted_retention_buffer.sv
// ----------------------------------------------------------------------------
// tb_timestamp_sorted_retention_buffer
// Drives pushes, range queries, gate updates and clears in bursts under
// several retention windows, with a stalling receiver; the checker judges.
// ----------------------------------------------------------------------------
module tb_timestamp_sorted_retention_buffer;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [trsb_pkg::STAMP_W-1:0] STAMP_MAX = {trsb_pkg::STAMP_W{1'b1}};
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending_results;
  int   idle_cycles = 0;
  logic [trsb_pkg::STAMP_W-1:0] clock_ns = '0;
  logic [trsb_pkg::STAMP_W-1:0] pushed_q[$];

  trsb_in_if  in_ch();
  trsb_out_if out_ch();
  trsb_cfg_if cfg_ch();

  always #6 clk = ~clk;

  timestamp_sorted_retention_buffer dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  trsb_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .cfg_mon(cfg_ch.sink), .fail_count(fail_count), .pending_results(pending_results)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = trsb_pkg::OP_PUSH;
    in_ch.stamp = '0;
    in_ch.stamp_end = '0;
    in_ch.payload = '0;
    in_ch.rejected_in = 1'b0;
    in_ch.evaluated_in = 1'b0;
    in_ch.distance_in = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
  end

  // Receiver stall pattern: phases of always-ready, mostly-ready and sparse.
  always @(negedge clk) begin
    int phase;
    phase = int'(($time / 3000) % 3);
    if (phase == 0) out_ch.ready <= 1'b1;
    else if (phase == 1) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_timestamp_sorted_retention_buffer: errors");
      $finish;
    end
  end

  task automatic send_item(trsb_pkg::op_t op, logic [trsb_pkg::STAMP_W-1:0] s,
                           logic [trsb_pkg::STAMP_W-1:0] e,
                           logic [trsb_pkg::PAY_W-1:0] pay, logic rej, logic ev,
                           logic [trsb_pkg::DIST_W-1:0] gate_dist);
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.stamp <= s;
    in_ch.stamp_end <= e;
    in_ch.payload <= pay;
    in_ch.rejected_in <= rej;
    in_ch.evaluated_in <= ev;
    in_ch.distance_in <= gate_dist;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (op == trsb_pkg::OP_PUSH) pushed_q.insert(pushed_q.size(), s);
    if (op == trsb_pkg::OP_CLEAR) pushed_q.delete();
  endtask

  task automatic pause_input();
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_window(logic [trsb_pkg::RET_W-1:0] w);
    while (pending_results != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [trsb_pkg::STAMP_W-1:0] rand_stamp();
    return trsb_pkg::STAMP_W'(rand64());
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom());
  endfunction

  // Random item, mostly a push slightly ahead of the running clock.
  task automatic random_item();
    logic [trsb_pkg::STAMP_W-1:0] s, e;
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) begin
      if ($urandom_range(0, 9) == 0 && clock_ns > 5000) s = clock_ns - $urandom_range(0, 5000);
      else begin
        clock_ns = clock_ns + $urandom_range(0, 400);
        s = clock_ns;
      end
      send_item(trsb_pkg::OP_PUSH, s, '0, rand64(), rand_bit(), rand_bit(), $urandom());
    end else if (k < 72) begin
      s = (clock_ns > 3000) ? clock_ns - $urandom_range(0, 3000) : '0;
      e = ($urandom_range(0, 3) == 0) ? STAMP_MAX : s + $urandom_range(0, 3000);
      send_item(trsb_pkg::OP_QUERY, s, e, rand64(), rand_bit(), rand_bit(), $urandom());
    end else if (k < 97) begin
      if (pushed_q.size() && $urandom_range(0, 3) != 0)
        s = pushed_q[$urandom_range(0, pushed_q.size() - 1)] + $urandom_range(0, 2) - 1;
      else s = clock_ns - $urandom_range(0, 50);
      send_item(trsb_pkg::OP_GATE, s, rand_stamp(), rand64(), rand_bit(), rand_bit(),
                $urandom());
    end else begin
      send_item(trsb_pkg::OP_CLEAR, rand_stamp(), rand_stamp(), rand64(), rand_bit(),
                rand_bit(), $urandom());
    end
  endtask

  task automatic random_phase(int count);
    int sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        random_item();
        sent++;
      end
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 8)) pause_input();
    end
    pause_input();
  endtask

  initial begin
    int wait_cycles;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty query, gate miss, field extremes, equal stamps, staleness.
    send_item(trsb_pkg::OP_QUERY, '0, STAMP_MAX, '0, 1'b0, 1'b0, '0);
    send_item(trsb_pkg::OP_GATE, '0, '0, '0, 1'b1, 1'b1, '1);
    send_item(trsb_pkg::OP_PUSH, '0, '0, '0, 1'b0, 1'b0, '0);
    send_item(trsb_pkg::OP_PUSH, 63'd5, '0, '1, 1'b1, 1'b1, '1);
    send_item(trsb_pkg::OP_PUSH, 63'd5, '0, 64'hA5A5_5A5A_0F0F_F0F0, 1'b0, 1'b1,
              32'h1234_5678);
    send_item(trsb_pkg::OP_GATE, 63'd6, '0, '0, 1'b1, 1'b0, 32'hFFFF_0000);
    send_item(trsb_pkg::OP_GATE, 63'd1, '0, '0, 1'b0, 1'b1, 32'h0000_FFFF);
    send_item(trsb_pkg::OP_QUERY, 63'd0, 63'd5, '0, 1'b0, 1'b0, '0);
    send_item(trsb_pkg::OP_PUSH, 63'd2_000_000_000, '0, rand64(), 1'b0, 1'b0, '0);
    send_item(trsb_pkg::OP_PUSH, 63'd3, '0, rand64(), 1'b1, 1'b0, '1);
    send_item(trsb_pkg::OP_QUERY, '0, STAMP_MAX, '0, 1'b0, 1'b0, '0);
    send_item(trsb_pkg::OP_PUSH, STAMP_MAX, '0, rand64(), 1'b1, 1'b1, '1);
    send_item(trsb_pkg::OP_GATE, STAMP_MAX, '1, '1, 1'b1, 1'b1, '1);
    send_item(trsb_pkg::OP_QUERY, STAMP_MAX - 1, STAMP_MAX, '1, 1'b1, 1'b1, '1);
    send_item(trsb_pkg::OP_CLEAR, '1, '1, '1, 1'b1, 1'b1, '1);
    send_item(trsb_pkg::OP_QUERY, '0, STAMP_MAX, '0, 1'b0, 1'b0, '0);
    pause_input();

    // Full store: fill past DEPTH, then push one older than everything.
    write_window('1);
    clock_ns = 63'd1000;
    repeat (trsb_pkg::DEPTH + 2) begin
      clock_ns = clock_ns + $urandom_range(0, 3);
      send_item(trsb_pkg::OP_PUSH, clock_ns, '0, rand64(), rand_bit(), rand_bit(),
                $urandom());
    end
    send_item(trsb_pkg::OP_PUSH, 63'd10, '0, rand64(), 1'b0, 1'b0, '0);
    send_item(trsb_pkg::OP_QUERY, '0, STAMP_MAX, '0, 1'b0, 1'b0, '0);
    random_phase(50);

    // Zero window: only entries equal to the newest stamp survive.
    write_window('0);
    random_phase(40);

    write_window(40'd1500);
    random_phase(60);

    write_window(40'd200);
    random_phase(40);

    write_window(trsb_pkg::RET_RESET);
    random_phase(37);

    wait_cycles = 0;
    while (pending_results != 0 && wait_cycles < IDLE_LIMIT) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (300) @(negedge clk);
    if (fail_count == 0 && pending_results == 0)
      $display("tb_timestamp_sorted_retention_buffer: clean");
    else
      $display("tb_timestamp_sorted_retention_buffer: errors");
    $finish;
  end

endmodule

FILE: timestamp_sorted_retention_buffer.f
hdl/trsb_pkg.sv
hdl/trsb_ifs.sv
hdl/trsb_front.sv
hdl/trsb_back.sv
hdl/timestamp_sorted_retention_buffer.sv
dv/trsb_checker.sv
dv/tb_timestamp_sorted_retention_buffer.sv
